@@ sv/page_bitmap_best_fit_allocator_defines.svh @@
// assertion macros for the page bitmap allocator
// used by the top level only, needs clk_i and rst_ni in scope
`ifndef PAGE_BITMAP_BEST_FIT_ALLOCATOR_DEFINES_SVH
`define PAGE_BITMAP_BEST_FIT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define PBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pba assertion failed");

// next-cycle implication
`define PBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pba assertion failed");

`endif

@@ sv/pba_pkg.sv @@
// shared types and constants of the page bitmap allocator
// no dependencies
package pba_pkg;

  localparam int unsigned PAGE_COUNT_DEF = 65536;
  localparam int unsigned PAGE_SHIFT     = 12;
  localparam int unsigned ADDR_W         = 28;
  localparam int unsigned LEN_W          = 29;
  localparam int unsigned ADDR_PAGE_W    = 16;
  localparam int unsigned CNT_W          = 18;
  localparam int unsigned MAP_WORD_W     = 64;

  localparam logic [1:0] OP_MARK_USED = 2'd0;
  localparam logic [1:0] OP_MARK_FREE = 2'd1;
  localparam logic [1:0] OP_ALLOC     = 2'd2;
  localparam logic [1:0] OP_FREE_PAGE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  typedef struct packed {
    logic load;
    logic init_wr;
    logic mk_rd;
    logic mk_wr;
    logic sc_start;
    logic sc_rd;
    logic sc_step;
    logic sc_close;
    logic alloc_mark;
    logic set_zero;
    logic set_nofit;
    logic out_load;
  } pba_cmd_t;

  typedef struct packed {
    logic init_last;
    logic is_alloc;
    logic len_zero;
    logic mk_skip;
    logic mk_last;
    logic chunk_last;
    logic word_last;
    logic found;
  } pba_sts_t;

endpackage

@@ sv/pba_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module pba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/pba_ctrl.sv @@
// controller state machine of the page bitmap allocator
// depends on pba_pkg
module pba_ctrl import pba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  pba_sts_t sts_i,
  output pba_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_INIT    = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_DISP    = 10'b0000000100,
    S_MK_RD   = 10'b0000001000,
    S_MK_WR   = 10'b0000010000,
    S_SC_RD   = 10'b0000100000,
    S_SCAN    = 10'b0001000000,
    S_SC_END  = 10'b0010000000,
    S_SC_DONE = 10'b0100000000,
    S_RESP    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.is_alloc) begin
          if (sts_i.len_zero) begin
            cmd_o.set_zero = 1'b1;
            state_d        = S_RESP;
          end else begin
            cmd_o.sc_start = 1'b1;
            state_d        = S_SC_RD;
          end
        end else if (sts_i.mk_skip) begin
          state_d = S_RESP;
        end else begin
          state_d = S_MK_RD;
        end
      end
      S_MK_RD: begin
        cmd_o.mk_rd = 1'b1;
        state_d     = S_MK_WR;
      end
      S_MK_WR: begin
        cmd_o.mk_wr = 1'b1;
        state_d     = sts_i.mk_last ? S_RESP : S_MK_RD;
      end
      S_SC_RD: begin
        cmd_o.sc_rd = 1'b1;
        state_d     = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.sc_step = 1'b1;
        if (sts_i.chunk_last && sts_i.word_last) state_d = S_SC_END;
      end
      S_SC_END: begin
        cmd_o.sc_close = 1'b1;
        state_d        = S_SC_DONE;
      end
      S_SC_DONE: begin
        if (sts_i.found) begin
          cmd_o.alloc_mark = 1'b1;
          state_d          = S_MK_RD;
        end else begin
          cmd_o.set_nofit = 1'b1;
          state_d         = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ sv/pba_dp.sv @@
// datapath of the page bitmap allocator: map ram, range marker, run scanner
// depends on pba_pkg and pba_ram
module pba_dp import pba_pkg::*; #(
  parameter int unsigned PAGE_COUNT = PAGE_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pba_cmd_t          cmd_i,
  output pba_sts_t          sts_o,
  input  logic [1:0]        operation_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [LEN_W-1:0]  length_bytes_i,
  output logic [ADDR_W-1:0] result_address_o,
  output logic [1:0]        status_o
);

  localparam int unsigned MAP_WORDS = (PAGE_COUNT + MAP_WORD_W - 1) / MAP_WORD_W;
  localparam int unsigned WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned PAGE_W    = $clog2(PAGE_COUNT);
  localparam int unsigned FP_W      = (PAGE_W > ADDR_PAGE_W) ? PAGE_W : ADDR_PAGE_W;
  localparam int unsigned END_W     = ((FP_W > CNT_W) ? FP_W : CNT_W) + 1;
  localparam int unsigned WIDX_W    = END_W - 6;
  localparam int unsigned RL_W      = $clog2(PAGE_COUNT + 1);
  localparam int unsigned CMP_W     = (RL_W > CNT_W) ? RL_W : CNT_W;

  logic [1:0]             op_q;
  logic                   lenz_q;
  logic [FP_W-1:0]        first_q;
  logic [END_W-1:0]       end_q;
  logic                   used_q;
  logic [CNT_W-1:0]       need_q;
  logic [WIDX_W-1:0]      cur_q;
  logic [WORD_AW-1:0]     init_q;
  logic [2:0]             chunk_q;
  logic [RL_W-1:0]        run_len_q, best_len_q;
  logic [PAGE_W-1:0]      run_start_q, best_start_q;
  logic                   found_q;
  logic [ADDR_W-1:0]      res_addr_q, out_addr_q;
  logic [1:0]             res_st_q, out_st_q;

  logic                   ram_we, ram_re;
  logic [WORD_AW-1:0]     ram_waddr, ram_raddr;
  logic [MAP_WORD_W-1:0]  ram_wdata, rdata, mask;

  logic [FP_W-1:0]        in_page;
  logic [CNT_W-1:0]       in_cnt, in_need;
  logic [END_W-1:0]       first_ext, end_m1;
  logic [WIDX_W-1:0]      cur_inc;

  logic [RL_W-1:0]        rl, bl;
  logic [PAGE_W-1:0]      rs, bs;
  logic                   fnd, is_free;
  logic [END_W-1:0]       g;
  logic [5:0]             bidx;
  logic                   cl_better;
  logic [FP_W-1:0]        bs_ext;

  pba_ram #(
    .WIDTH (MAP_WORD_W),
    .DEPTH (MAP_WORDS),
    .AW    (WORD_AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign in_page   = FP_W'(address_i[ADDR_W-1:PAGE_SHIFT]);
  assign in_need   = CNT_W'(length_bytes_i[LEN_W-1:PAGE_SHIFT])
                   + CNT_W'(|length_bytes_i[PAGE_SHIFT-1:0]);
  assign first_ext = END_W'(first_q);
  assign end_m1    = end_q - END_W'(1);
  assign cur_inc   = cur_q + WIDX_W'(1);
  assign bs_ext    = FP_W'(best_start_q);

  always_comb begin
    case (operation_i)
      OP_FREE_PAGE: in_cnt = CNT_W'(1);
      OP_ALLOC:     in_cnt = in_need;
      default:      in_cnt = CNT_W'(length_bytes_i[LEN_W-1:PAGE_SHIFT]);
    endcase
  end

  // per-page mask for the word at cur_q
  always_comb begin
    for (int i = 0; i < MAP_WORD_W; i++) begin
      mask[i] = ({cur_q, 6'(i)} >= first_ext) && ({cur_q, 6'(i)} < end_q)
             && ({cur_q, 6'(i)} < END_W'(PAGE_COUNT));
    end
  end

  assign ram_we    = cmd_i.init_wr | cmd_i.mk_wr;
  assign ram_waddr = cmd_i.init_wr ? init_q : cur_q[WORD_AW-1:0];
  assign ram_wdata = cmd_i.init_wr ? '1 : (used_q ? (rdata | mask) : (rdata & ~mask));
  assign ram_re    = cmd_i.mk_rd | cmd_i.sc_rd
                   | (cmd_i.sc_step & sts_o.chunk_last & ~sts_o.word_last);
  assign ram_raddr = cmd_i.sc_step ? cur_inc[WORD_AW-1:0] : cur_q[WORD_AW-1:0];

  // run tracking over eight pages of the current word
  always_comb begin
    rl = run_len_q;
    rs = run_start_q;
    bl = best_len_q;
    bs = best_start_q;
    fnd = found_q;
    g = '0;
    bidx = '0;
    is_free = 1'b0;
    for (int j = 0; j < 8; j++) begin
      bidx    = {chunk_q, 3'(j)};
      g       = {cur_q, bidx};
      is_free = !rdata[bidx] && (g < END_W'(PAGE_COUNT));
      if (is_free) begin
        if (rl == '0) rs = g[PAGE_W-1:0];
        rl = rl + RL_W'(1);
      end else if (rl != '0) begin
        if ((CMP_W'(rl) >= CMP_W'(need_q)) && (!fnd || rl < bl)) begin
          fnd = 1'b1;
          bs  = rs;
          bl  = rl;
        end
        rl = '0;
      end
    end
  end

  assign cl_better = (run_len_q != '0) && (CMP_W'(run_len_q) >= CMP_W'(need_q))
                  && (!found_q || run_len_q < best_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
    end else if (cmd_i.init_wr) begin
      init_q <= init_q + WORD_AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= operation_i;
      lenz_q     <= (length_bytes_i == '0);
      first_q    <= in_page;
      end_q      <= END_W'(in_page) + END_W'(in_cnt);
      cur_q      <= WIDX_W'(END_W'(in_page) >> 6);
      used_q     <= (operation_i == OP_MARK_USED);
      need_q     <= in_need;
      res_addr_q <= '0;
      res_st_q   <= ST_OK;
    end
    if (cmd_i.mk_wr) cur_q <= cur_inc;
    if (cmd_i.sc_start) begin
      cur_q     <= '0;
      chunk_q   <= '0;
      run_len_q <= '0;
      found_q   <= 1'b0;
    end
    if (cmd_i.sc_step) begin
      chunk_q      <= chunk_q + 3'd1;
      if (chunk_q == 3'd7) cur_q <= cur_inc;
      run_len_q    <= rl;
      run_start_q  <= rs;
      best_len_q   <= bl;
      best_start_q <= bs;
      found_q      <= fnd;
    end
    if (cmd_i.sc_close && cl_better) begin
      found_q      <= 1'b1;
      best_start_q <= run_start_q;
      best_len_q   <= run_len_q;
    end
    if (cmd_i.alloc_mark) begin
      first_q    <= bs_ext;
      end_q      <= END_W'(best_start_q) + END_W'(need_q);
      cur_q      <= WIDX_W'(END_W'(best_start_q) >> 6);
      used_q     <= 1'b1;
      res_addr_q <= {bs_ext[ADDR_PAGE_W-1:0], {PAGE_SHIFT{1'b0}}};
    end
    if (cmd_i.set_zero)  res_st_q <= ST_ZERO;
    if (cmd_i.set_nofit) res_st_q <= ST_NOFIT;
    if (cmd_i.out_load) begin
      out_addr_q <= res_addr_q;
      out_st_q   <= res_st_q;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.init_last  = (init_q == WORD_AW'(MAP_WORDS - 1));
    sts_o.is_alloc   = (op_q == OP_ALLOC);
    sts_o.len_zero   = lenz_q;
    sts_o.mk_skip    = (end_q == first_ext) || (first_ext >= END_W'(PAGE_COUNT));
    sts_o.word_last  = (cur_q == WIDX_W'(MAP_WORDS - 1));
    sts_o.mk_last    = (cur_q >= end_m1[END_W-1:6]) || sts_o.word_last;
    sts_o.chunk_last = (chunk_q == 3'd7);
    sts_o.found      = found_q;
  end

  assign result_address_o = out_addr_q;
  assign status_o         = out_st_q;

endmodule

@@ sv/page_bitmap_best_fit_allocator.sv @@
// Best-fit page allocator over a one-bit-per-page used map of 4 KiB pages, held in a
// ram of 64-bit words (PAGE_COUNT/64 words). After reset a clearing pass writes every
// word to all used, one word a cycle, with no word accepted. One word is worked at a
// time. Marking a range reads, modifies and writes back each map word touched on the
// map ram; freeing one page does the same for its one word. An allocation scans the
// whole map eight pages a cycle, then marks the chosen pages as above. Results sit in
// an output register, so a result can wait while the next word is taken.
// depends on pba_pkg, pba_ctrl, pba_dp and the defines header
`include "page_bitmap_best_fit_allocator_defines.svh"

module page_bitmap_best_fit_allocator import pba_pkg::*; #(
  parameter int unsigned PAGE_COUNT = PAGE_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [LEN_W-1:0]  length_bytes_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] result_address_o,
  output logic [1:0]        status_o
);

  pba_cmd_t cmd;
  pba_sts_t sts;

  pba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pba_dp #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (operation_i),
    .address_i        (address_i),
    .length_bytes_i   (length_bytes_i),
    .result_address_o (result_address_o),
    .status_o         (status_o)
  );

  `PBA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `PBA_ASSERT_NOW(a_err_zero_addr, out_valid_o && status_o != ST_OK, result_address_o == '0)
  `PBA_ASSERT_NOW(a_page_aligned, out_valid_o, result_address_o[PAGE_SHIFT-1:0] == '0)

endmodule
